[hw/rtl/m4mf_pkg.sv]
// ----------------------------------------------------------------------------
// m4mf_pkg
// Shared types and codes for the 4x4 fixed-point matrix multiplier: command
// codes, the input and result words, the controller states and the command
// and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package m4mf_pkg;

  // Command codes carried in the input word
  typedef enum logic [1:0] {
    CMD_LOAD_FIRST  = 2'd0,
    CMD_LOAD_SECOND = 2'd1,
    CMD_COMPUTE     = 2'd2
  } cmd_t;

  // Input word: one load or one compute request
  typedef struct packed {
    logic [1:0]         command;
    logic [3:0]         element_index;
    logic signed [31:0] element_value;
  } in_word_t;

  // Result word: one product element
  typedef struct packed {
    logic [3:0]         result_index;
    logic signed [31:0] result_value;
    logic               last_result;
  } out_word_t;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic       wr_first;   // write the input word into the first matrix
    logic       wr_second;  // write the input word into the second matrix
    logic       rd_en;      // issue one product term
    logic       first_term; // term opens a new element sum
    logic       last_term;  // term closes the element sum
    logic [3:0] elem;       // column-major element of the product
    logic [1:0] term;       // summation index
  } ctl_t;

  // Datapath to controller status
  typedef struct packed {
    logic last_out;         // final element of the run is on the outputs
  } stat_t;

  // Per-stage tag travelling down the datapath pipeline
  typedef struct packed {
    logic       valid;
    logic       first_term;
    logic       last_term;
    logic [3:0] elem;
  } tag_t;

endpackage

[hw/rtl/m4mf_ctrl.sv]
// ----------------------------------------------------------------------------
// m4mf_ctrl
// Controller state machine: decodes load and compute commands and steps
// through the 64 product terms of a compute run, one per cycle.
// ----------------------------------------------------------------------------
module m4mf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         command,
  input  m4mf_pkg::stat_t    stat,
  output logic               busy,
  output m4mf_pkg::ctl_t     ctl
);

  m4mf_pkg::state_t state;
  m4mf_pkg::state_t state_next;
  logic [5:0]       step;
  logic [5:0]       step_next;

  // Advance state and term counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= m4mf_pkg::ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      m4mf_pkg::ST_IDLE: begin
        step_next = '0;
        if (start && command == m4mf_pkg::CMD_COMPUTE) begin
          state_next = m4mf_pkg::ST_RUN;
        end
      end
      m4mf_pkg::ST_RUN: begin
        step_next = step + 6'd1;
        if (&step) begin
          state_next = m4mf_pkg::ST_DRAIN;
        end
      end
      m4mf_pkg::ST_DRAIN: begin
        if (stat.last_out) begin
          state_next = m4mf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = m4mf_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs: step splits into element (upper bits) and term (lower bits)
  always_comb begin
    busy           = 1'b1;
    ctl.wr_first   = 1'b0;
    ctl.wr_second  = 1'b0;
    ctl.rd_en      = 1'b0;
    ctl.first_term = (step[1:0] == 2'd0);
    ctl.last_term  = (step[1:0] == 2'd3);
    ctl.elem       = step[5:2];
    ctl.term       = step[1:0];
    unique case (state)
      m4mf_pkg::ST_IDLE: begin
        busy          = 1'b0;
        ctl.wr_first  = start && command == m4mf_pkg::CMD_LOAD_FIRST;
        ctl.wr_second = start && command == m4mf_pkg::CMD_LOAD_SECOND;
      end
      m4mf_pkg::ST_RUN: begin
        ctl.rd_en = 1'b1;
      end
      m4mf_pkg::ST_DRAIN: begin
        ctl.rd_en = 1'b0;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

[hw/rtl/m4mf_datapath.sv]
// ----------------------------------------------------------------------------
// m4mf_datapath
// Matrix stores, one multiplier and an accumulator: read one element of each
// matrix, multiply, sum four exact products, then shift and saturate.
// ----------------------------------------------------------------------------
module m4mf_datapath #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  m4mf_pkg::ctl_t      ctl,
  input  m4mf_pkg::in_word_t  operand,
  output m4mf_pkg::stat_t     stat,
  output logic                strobe,
  output m4mf_pkg::out_word_t result
);

  localparam int PROD_W = 2 * WORD_BITS;
  localparam int ACC_W  = PROD_W + 2;
  localparam int TOP_W  = ACC_W - WORD_BITS + 1;

  logic signed [WORD_BITS-1:0] mem_first  [16];
  logic signed [WORD_BITS-1:0] mem_second [16];

  logic signed [WORD_BITS-1:0] wr_data;
  logic [3:0]                  addr_first;
  logic [3:0]                  addr_second;
  logic signed [WORD_BITS-1:0] rd_first;
  logic signed [WORD_BITS-1:0] rd_second;
  logic signed [PROD_W-1:0]    prod;
  logic signed [ACC_W-1:0]     acc;
  logic signed [ACC_W-1:0]     shifted;
  logic [TOP_W-1:0]            top_bits;
  logic signed [WORD_BITS-1:0] sat_word;
  m4mf_pkg::tag_t              tag_rd;
  m4mf_pkg::tag_t              tag_prod;
  m4mf_pkg::tag_t              tag_acc;

  // Take the low word bits of the input, sign-extending when the word is wide
  assign wr_data = WORD_BITS'(operand.element_value);

  // First matrix is read down a row, second down a column
  assign addr_first  = {ctl.term, ctl.elem[1:0]};
  assign addr_second = {ctl.elem[3:2], ctl.term};

  // Matrix stores: one write and one read each per cycle
  always_ff @(posedge clk) begin
    if (ctl.wr_first) begin
      mem_first[operand.element_index] <= wr_data;
    end
    if (ctl.wr_second) begin
      mem_second[operand.element_index] <= wr_data;
    end
    rd_first  <= mem_first[addr_first];
    rd_second <= mem_second[addr_second];
  end

  // Advance the pipeline tags
  always_ff @(posedge clk) begin
    if (rst) begin
      tag_rd   <= '0;
      tag_prod <= '0;
      tag_acc  <= '0;
      strobe   <= 1'b0;
    end else begin
      tag_rd.valid      <= ctl.rd_en;
      tag_rd.first_term <= ctl.first_term;
      tag_rd.last_term  <= ctl.last_term;
      tag_rd.elem       <= ctl.elem;
      tag_prod          <= tag_rd;
      tag_acc           <= tag_prod;
      strobe            <= tag_acc.valid && tag_acc.last_term;
    end
  end

  // Multiply, then accumulate the exact product
  always_ff @(posedge clk) begin
    prod <= rd_first * rd_second;
    if (tag_prod.valid) begin
      acc <= (tag_prod.first_term ? ACC_W'(0) : acc) + ACC_W'(prod);
    end
  end

  // Shift arithmetically and clamp when the upper bits disagree with the sign
  assign shifted  = acc >>> FRAC_BITS;
  assign top_bits = shifted[ACC_W-1:WORD_BITS-1];

  always_comb begin
    priority if (!shifted[ACC_W-1] && (|top_bits)) begin
      sat_word = {1'b0, {(WORD_BITS-1){1'b1}}};
    end else if (shifted[ACC_W-1] && !(&top_bits)) begin
      sat_word = {1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      sat_word = shifted[WORD_BITS-1:0];
    end
  end

  // Register the result word
  always_ff @(posedge clk) begin
    if (tag_acc.valid && tag_acc.last_term) begin
      result.result_index <= tag_acc.elem;
      result.result_value <= 32'($unsigned(sat_word));
      result.last_result  <= &tag_acc.elem;
    end
  end

  assign stat.last_out = strobe && result.last_result;

endmodule

[hw/rtl/mat4_multiply_fixed_top.sv]
// ----------------------------------------------------------------------------
// mat4_multiply_fixed_top
// 4x4 column-major matrix multiplier in signed fixed point.
// ----------------------------------------------------------------------------
// A load word (first or second matrix) is taken in the cycle it is offered,
// and busy stays low so loads may follow back to back. A compute word holds
// busy high while the single multiplier works one product term per cycle, 64
// terms in all, behind a four-stage read, multiply, accumulate and output
// pipeline, and until the last result is out. The sixteen results leave in
// column-major order; each is on result for a single cycle with strobe high,
// and the receiver must take it then, as it cannot stall the block.
// Elements must be loaded before they are used.
// ----------------------------------------------------------------------------
module mat4_multiply_fixed_top #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  m4mf_pkg::in_word_t  operand,
  output logic                strobe,
  output m4mf_pkg::out_word_t result
);

  m4mf_pkg::ctl_t  ctl;
  m4mf_pkg::stat_t stat;

  // Command decode and term sequencing
  m4mf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (operand.command),
    .stat    (stat),
    .busy    (busy),
    .ctl     (ctl)
  );

  // Stores, multiplier and accumulator
  m4mf_datapath #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .operand (operand),
    .stat    (stat),
    .strobe  (strobe),
    .result  (result)
  );

endmodule

[verif/mat4_multiply_fixed_top_tb.sv]
// ----------------------------------------------------------------------------
// mat4_multiply_fixed_top_tb
// Self-checking bench for the 4x4 column-major fixed-point matrix multiplier.
// Load words fill both matrices and compute words request the sixteen product
// elements. A local predictor keeps its own copy of both matrices, forms each
// element as an exact sum of four products, shifts it down by the fraction
// width and saturates it. Every strobed result is checked in order against
// the predicted elements. The sender idles at random in several phases.
// ----------------------------------------------------------------------------
module mat4_multiply_fixed_top_tb;

  localparam int WORD_BITS   = 32;
  localparam int FRAC_BITS   = 16;
  localparam int RESET_CYCLES = 10;
  localparam int PHASE_WORDS = 104;
  localparam int TAIL_CYCLES = 80;
  localparam int CYCLE_LIMIT = 200000;

  // Command code the block does not decode
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  // Sender idling per phase, in percent of cycles
  localparam int unsigned IDLE_NONE  = 0;
  localparam int unsigned IDLE_HEAVY = 84;
  localparam int unsigned IDLE_LIGHT = 12;

  localparam logic signed [65:0] SUM_MAX  = 66'sh0_7FFF_FFFF;
  localparam logic signed [65:0] SUM_MIN  = -66'sh0_8000_0000;
  localparam logic signed [31:0] WORD_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] WORD_MIN = 32'sh8000_0000;

  typedef struct {
    m4mf_pkg::in_word_t w;
    int unsigned        idle_pct;
    bit                 settle;    // offer only once every product element has come
  } pending_word_t;

  logic                clk;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  m4mf_pkg::in_word_t  operand = '0;
  logic                strobe;
  m4mf_pkg::out_word_t result;

  pending_word_t       word_q[$];
  m4mf_pkg::out_word_t product_q[$];
  logic signed [31:0]  mat_a [16];
  logic signed [31:0]  mat_b [16];

  bit settle_next;
  int total_words;
  int words_taken;
  int loads_seen;
  int computes_seen;
  int ignored_seen;
  int saturated_seen;
  int elements_checked;
  int errors;
  int cycle_count;

  mat4_multiply_fixed_top #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .operand(operand),
    .strobe (strobe),
    .result (result)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h, want %0h", cycle_count, what, got, want);
    errors++;
  endtask

  // Update the matrices or predict the sixteen product elements for one word
  task automatic apply_word(input m4mf_pkg::in_word_t w);
    logic signed [65:0]  sum;
    logic signed [65:0]  shifted;
    logic signed [65:0]  a;
    logic signed [65:0]  b;
    m4mf_pkg::out_word_t e;
    words_taken++;
    case (w.command)
      m4mf_pkg::CMD_LOAD_FIRST: begin
        mat_a[w.element_index] = w.element_value;
        loads_seen++;
      end
      m4mf_pkg::CMD_LOAD_SECOND: begin
        mat_b[w.element_index] = w.element_value;
        loads_seen++;
      end
      m4mf_pkg::CMD_COMPUTE: begin
        for (int k = 0; k < 16; k++) begin
          sum = '0;
          for (int i = 0; i < 4; i++) begin
            a = mat_a[i * 4 + k % 4];
            b = mat_b[(k / 4) * 4 + i];
            sum += a * b;
          end
          // floor division by the fraction scale, then clamp to the word
          shifted = sum >>> FRAC_BITS;
          e.result_index = 4'(k);
          e.last_result  = (k == 15);
          if (shifted > SUM_MAX) begin
            e.result_value = WORD_MAX;
            saturated_seen++;
          end else if (shifted < SUM_MIN) begin
            e.result_value = WORD_MIN;
            saturated_seen++;
          end else begin
            e.result_value = shifted[31:0];
          end
          product_q.push_back(e);
        end
        computes_seen++;
      end
      default: ignored_seen++;
    endcase
  endtask

  function automatic bit ready_to_offer(input pending_word_t p);
    if (p.settle && (product_q.size() != 0 || strobe))
      return 1'b0;
    return $urandom_range(99) >= p.idle_pct;
  endfunction

  task automatic queue_word(input logic [1:0] cmd, input int idx,
                            input logic signed [31:0] val, input int unsigned idle);
    pending_word_t p;
    p.w.command       = cmd;
    p.w.element_index = 4'(idx);
    p.w.element_value = val;
    p.idle_pct        = idle;
    p.settle          = settle_next;
    settle_next       = 1'b0;
    word_q.push_back(p);
  endtask

  function automatic logic signed [31:0] extreme_value(input int n);
    case (n % 8)
      0: return WORD_MAX;
      1: return WORD_MIN;
      2: return 32'sd0;
      3: return 32'sd1;
      4: return -32'sd1;
      5: return 32'sh0001_0000;
      6: return 32'shFFFF_0000;
      default: return 32'sh0000_8000;
    endcase
  endfunction

  // Mostly modest values, with full-range words and extremes mixed in
  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(7))
      0, 1: return $urandom;
      2: return extreme_value($urandom_range(7));
      default: return int'($urandom_range(524288)) - 262144;
    endcase
  endfunction

  function automatic logic [1:0] rand_load_cmd();
    return $urandom_range(1) ? m4mf_pkg::CMD_LOAD_SECOND : m4mf_pkg::CMD_LOAD_FIRST;
  endfunction

  function automatic int unsigned phase_idle(input int ph);
    case (ph)
      1: return IDLE_HEAVY;
      3: return IDLE_LIGHT;
      default: return IDLE_NONE;
    endcase
  endfunction

  // Driver: hold a word until taken, otherwise offer the next one or idle
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_word(operand);
      end
      if (!(start && busy)) begin
        if (word_q.size() != 0 && ready_to_offer(word_q[0])) begin
          operand <= word_q[0].w;
          start   <= 1'b1;
          void'(word_q.pop_front());
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each strobed element with the oldest prediction
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (product_q.size() == 0) begin
        report_mismatch("unexpected element, index", 32'(result.result_index), '0);
      end else begin
        if (result.result_index !== product_q[0].result_index)
          report_mismatch("result_index", 32'(result.result_index),
                          32'(product_q[0].result_index));
        if (result.result_value !== product_q[0].result_value)
          report_mismatch("result_value", result.result_value, product_q[0].result_value);
        if (result.last_result !== product_q[0].last_result)
          report_mismatch("last_result", 32'(result.last_result),
                          32'(product_q[0].last_result));
        void'(product_q.pop_front());
        elements_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d elements outstanding", cycle_count,
               product_q.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    int unsigned idle;
    int          counted;
    int          n;
    int          roll;

    // Directed: every element of both matrices, row 0 of A at the top of the
    // range against column 0 of B high and column 1 low, so both clamps occur
    settle_next = 1'b0;
    for (int k = 0; k < 16; k++)
      queue_word(m4mf_pkg::CMD_LOAD_FIRST, k, (k % 4 == 0) ? WORD_MAX : extreme_value(k),
                 IDLE_NONE);
    for (int k = 15; k >= 0; k--)
      queue_word(m4mf_pkg::CMD_LOAD_SECOND, k,
                 (k < 4) ? WORD_MAX : (k < 8) ? WORD_MIN : extreme_value(k * 3), IDLE_NONE);
    queue_word(CMD_UNUSED, $urandom_range(15), $urandom, IDLE_NONE);
    queue_word(m4mf_pkg::CMD_COMPUTE, $urandom_range(15), $urandom, IDLE_NONE);

    // Random: load bursts closed by a compute, broken bursts and unused words
    for (int ph = 0; ph < 4; ph++) begin
      idle        = phase_idle(ph);
      settle_next = 1'b1;
      counted     = 0;
      while (counted < PHASE_WORDS) begin
        roll = $urandom_range(99);
        if (roll < 5) begin
          queue_word(CMD_UNUSED, $urandom_range(15), $urandom, idle);
        end else if (roll < 15) begin
          n = $urandom_range(4, 1);
          repeat (n) queue_word(rand_load_cmd(), $urandom_range(15), rand_value(), idle);
          counted += n;
        end else begin
          n = $urandom_range(6);
          repeat (n) queue_word(rand_load_cmd(), $urandom_range(15), rand_value(), idle);
          queue_word(m4mf_pkg::CMD_COMPUTE, $urandom_range(15), $urandom, idle);
          counted += n + 1;
        end
      end
    end
    total_words = word_q.size();

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Drain: all words taken, all elements seen, then a quiet tail
    while (words_taken < total_words) @(posedge clk);
    while (product_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("%0d loads, %0d compute runs and %0d unused words in %0d cycles",
             loads_seen, computes_seen, ignored_seen, cycle_count);
    $display("%0d product elements checked, %0d of them clamped", elements_checked,
             saturated_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
